### hdl/acr_pkg.sv
// Package for the ARP cache resolver: action codes, register indexes, constants.
// No dependencies; used by the core, the checker and the testbench.
package acr_pkg;
    localparam logic [2:0] ACT_NONE    = 3'd0;
    localparam logic [2:0] ACT_DIRECT  = 3'd1;
    localparam logic [2:0] ACT_REQUEST = 3'd2;
    localparam logic [2:0] ACT_RELEASE = 3'd3;
    localparam logic [2:0] ACT_REPLY   = 3'd4;

    localparam logic [15:0] ARP_ETHERTYPE = 16'h0806;
    localparam logic [15:0] HW_ETHERNET   = 16'h0001;
    localparam logic [15:0] PROTO_IPV4    = 16'h0800;
    localparam logic [15:0] OP_REQUEST    = 16'h0001;
    localparam logic [15:0] OP_REPLY      = 16'h0002;

    localparam logic REG_LOCAL_IP = 1'b0;
    localparam logic REG_LIFETIME = 1'b1;

    localparam int ENTRY_W = 32 + 48 + 32;

    typedef struct packed {
        logic [31:0] ip;
        logic [47:0] mac;
        logic [31:0] expiry;
    } t_entry;
endpackage

### hdl/acr_ram.sv
// Generic single-port-write, single-read synchronous RAM with registered read.
// No dependencies.
module acr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

### hdl/arp_cache_resolver_core.sv
// ARP cache resolver: input/output channels, APB register port, entry RAM and sequencer.
// Depends on acr_pkg and acr_ram.
//
// Use: one word on the input channel is either a received ARP header (cmd 0)
// or an outbound lookup (cmd 1), stamped with the current time in seconds.
// Every accepted word gives exactly one result word on the output channel.
// Both channels are valid/ready; the result sits in an output register.
// A lookup scans the table through the read port, then posts its result; a
// good header runs the ageing and victim scan, writes the learned entry and
// posts, and when a send is parked the table is searched for it after the
// write, before the post; a header that fails its checks is posted directly.
// The scans go through the single read port of the entry RAM.
// One item is in work at a time; the next word is accepted the cycle after
// the result has gone into the output register, even while it still waits.
// If the receiver stalls with a result held and one more finished, the
// sequencer holds until the register frees.
// Reset clears the valid bits, the pending slot and registers (local_ip 0,
// lifetime 60); entry RAM contents need no clearing.
// Registers: 0x0 local_ip, 0x4 entry_lifetime, via APB; pready is always high.
module arp_cache_resolver_core #(
    parameter int TABLE_ENTRIES = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_cmd,
    input  logic [31:0] i_now_seconds,
    input  logic [15:0] i_hw_type,
    input  logic [15:0] i_proto_type,
    input  logic [7:0]  i_hw_len,
    input  logic [7:0]  i_proto_len,
    input  logic [15:0] i_opcode,
    input  logic [31:0] i_src_ip,
    input  logic [47:0] i_src_mac,
    input  logic [31:0] i_dst_ip,
    input  logic [15:0] i_upper_protocol,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_action,
    output logic [47:0] o_dest_mac,
    output logic [31:0] o_dest_ip,
    output logic [15:0] o_frame_protocol,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1) + 1;
    localparam logic [CW-1:0] LAST = CW'(TABLE_ENTRIES - 1);

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;  // aging + victim scan
    localparam logic [2:0] S_WRITE = 3'd2;  // learn write
    localparam logic [2:0] S_FIND  = 3'd3;  // lookup scan
    localparam logic [2:0] S_DONE  = 3'd4;  // post result

    // registers
    logic [31:0] r_local_ip;
    logic [15:0] r_lifetime;
    logic        cfg_we;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_local_ip <= '0;
            r_lifetime <= 16'd60;
        end else if (cfg_we) begin
            if (paddr[2] == acr_pkg::REG_LOCAL_IP && paddr[1:0] == 2'b00) begin
                r_local_ip <= pwdata;
            end else if (paddr[2] == acr_pkg::REG_LIFETIME && paddr[1:0] == 2'b00) begin
                r_lifetime <= pwdata[15:0];
            end
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[1:0] == 2'b00) begin
            if (paddr[2] == acr_pkg::REG_LOCAL_IP) begin
                prdata = r_local_ip;
            end else begin
                prdata = {16'd0, r_lifetime};
            end
        end
    end

    // item and working state
    logic [2:0]  r_state, n_state;
    logic        r_cmd;
    logic [31:0] r_now, r_sip, r_tip;
    logic [47:0] r_smac;
    logic [15:0] r_uproto;
    logic        r_is_req;
    logic [TABLE_ENTRIES-1:0] r_valid, n_valid;
    logic        r_pend_v;
    logic [31:0] r_pend_ip;
    logic [15:0] r_pend_proto;
    logic [CW-1:0] r_cnt;       // read address issued
    logic        r_rd_v;        // read data valid this cycle
    logic [AW-1:0] r_rd_idx;
    logic        r_have_free;
    logic [AW-1:0] r_slot;
    logic [31:0] r_min_exp;
    logic        r_hit;
    logic [47:0] r_hit_mac;
    logic [31:0] r_key;

    // result of the finished item
    logic [2:0]  n_act;
    logic [47:0] n_omac;
    logic [31:0] n_oip;
    logic [15:0] n_oproto;
    logic        r_hdr_fail;

    // output register
    logic        r_ovalid;
    logic [2:0]  r_act;
    logic [47:0] r_omac;
    logic [31:0] r_oip;
    logic [15:0] r_oproto;

    assign o_valid          = r_ovalid;
    assign o_action         = r_act;
    assign o_dest_mac       = r_omac;
    assign o_dest_ip        = r_oip;
    assign o_frame_protocol = r_oproto;
    assign o_ready          = (r_state == S_IDLE);

    // entry RAM
    acr_pkg::t_entry rd_entry, wr_entry;
    logic [AW-1:0] raddr;
    logic          ram_we;
    logic [32:0]   exp_sum;

    assign raddr   = r_cnt[AW-1:0];
    assign exp_sum = {1'b0, r_now} + {17'd0, r_lifetime};
    assign wr_entry.ip     = r_sip;
    assign wr_entry.mac    = r_smac;
    assign wr_entry.expiry = exp_sum[32] ? 32'hFFFF_FFFF : exp_sum[31:0];
    assign ram_we = (r_state == S_WRITE);

    acr_ram #(.WIDTH(acr_pkg::ENTRY_W), .DEPTH(TABLE_ENTRIES)) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(r_slot),
        .i_wdata(wr_entry),
        .i_raddr(raddr),
        .o_rdata(rd_entry)
    );

    logic hdr_ok;
    assign hdr_ok = (i_hw_type == acr_pkg::HW_ETHERNET)
        && (i_proto_type == acr_pkg::PROTO_IPV4)
        && (i_hw_len == 8'd6) && (i_proto_len == 8'd4)
        && ((i_opcode == acr_pkg::OP_REQUEST) || (i_opcode == acr_pkg::OP_REPLY));

    logic out_free;
    assign out_free = !r_ovalid || i_ready;

    logic scan_end;
    assign scan_end = r_rd_v && (r_rd_idx == LAST[AW-1:0]);

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_valid  <= '0;
            r_pend_v <= 1'b0;
            r_ovalid <= 1'b0;
            r_rd_v   <= 1'b0;
            r_cnt    <= '0;
        end else begin
            // result held while stalled, loaded when posted
            r_ovalid <= ((r_state == S_DONE) && out_free) || (r_ovalid && !i_ready);
            r_rd_v   <= ((r_state == S_SCAN) || (r_state == S_FIND)) && (r_cnt <= LAST);
            r_rd_idx <= raddr;
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_cmd    <= i_cmd;
                        r_now    <= i_now_seconds;
                        r_sip    <= i_src_ip;
                        r_smac   <= i_src_mac;
                        r_tip    <= i_dst_ip;
                        r_uproto <= i_upper_protocol;
                        r_is_req <= (i_opcode == acr_pkg::OP_REQUEST);
                        r_cnt    <= '0;
                        r_hit    <= 1'b0;
                        r_have_free <= 1'b0;
                        r_slot   <= '0;
                        r_min_exp <= 32'hFFFF_FFFF;
                        if (i_cmd) begin
                            r_key   <= i_dst_ip;
                            r_state <= S_FIND;
                        end else if (hdr_ok) begin
                            r_state <= S_SCAN;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_SCAN, S_FIND: begin
                    if (r_cnt <= LAST) begin
                        r_cnt  <= r_cnt + 1'b1;
                    end
                    if (r_rd_v) begin
                        if (r_state == S_SCAN) begin
                            // age, then pick lowest free or earliest expiry
                            if (!n_valid[r_rd_idx]) begin
                                if (!r_have_free) begin
                                    r_have_free <= 1'b1;
                                    r_slot      <= r_rd_idx;
                                end
                            end else if (!r_have_free && (r_rd_idx == '0
                                         || rd_entry.expiry < r_min_exp)) begin
                                r_min_exp <= rd_entry.expiry;
                                r_slot    <= r_rd_idx;
                            end
                            r_valid <= n_valid;
                        end else if (!r_hit && r_valid[r_rd_idx]
                                     && rd_entry.ip == r_key) begin
                            r_hit     <= 1'b1;
                            r_hit_mac <= rd_entry.mac;
                        end
                    end
                    if (scan_end) begin
                        r_state <= (r_state == S_SCAN) ? S_WRITE : S_DONE;
                        r_cnt   <= '0;
                    end
                end
                S_WRITE: begin
                    r_valid[r_slot] <= 1'b1;
                    r_key <= r_pend_ip;
                    if (r_pend_v) begin
                        r_state <= S_FIND;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_act    <= n_act;
                        r_omac   <= n_omac;
                        r_oip    <= n_oip;
                        r_oproto <= n_oproto;
                        if (r_cmd && !r_hit) begin
                            r_pend_v     <= 1'b1;
                            r_pend_ip    <= r_tip;
                            r_pend_proto <= r_uproto;
                        end else if (!r_cmd && n_act == acr_pkg::ACT_RELEASE) begin
                            r_pend_v <= 1'b0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // aging of the entry just read
    always_comb begin
        n_valid = r_valid;
        if (r_valid[r_rd_idx] && r_now > rd_entry.expiry) begin
            n_valid[r_rd_idx] = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE) begin
            r_hdr_fail <= !i_cmd && !hdr_ok;
        end
    end

    always_comb begin
        n_act    = acr_pkg::ACT_NONE;
        n_omac   = '0;
        n_oip    = '0;
        n_oproto = '0;
        if (r_cmd) begin
            if (r_hit) begin
                n_act    = acr_pkg::ACT_DIRECT;
                n_omac   = r_hit_mac;
                n_oproto = r_uproto;
            end else begin
                n_act    = acr_pkg::ACT_REQUEST;
                n_oip    = r_tip;
                n_oproto = acr_pkg::ARP_ETHERTYPE;
            end
        end else if (!r_hdr_fail) begin
            if (r_pend_v) begin
                if (r_hit) begin
                    n_act    = acr_pkg::ACT_RELEASE;
                    n_omac   = r_hit_mac;
                    n_oproto = r_pend_proto;
                end
            end else if (r_is_req && r_tip == r_local_ip) begin
                n_act    = acr_pkg::ACT_REPLY;
                n_omac   = r_smac;
                n_oip    = r_sip;
                n_oproto = acr_pkg::ARP_ETHERTYPE;
            end
        end
    end
endmodule

### hdl/acr_checker.sv
// Port-level checker for the ARP cache resolver, bound to the top level.
// Depends on acr_pkg and arp_cache_resolver_core.
module acr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic [2:0]  o_action,
    input logic [47:0] o_dest_mac,
    input logic [31:0] o_dest_ip,
    input logic [15:0] o_frame_protocol
);
    // a held result keeps its valid and its action code
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_action))
        else $error("result changed while stalled");

    // action codes stay in range
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_action <= acr_pkg::ACT_REPLY)
        else $error("bad action");

    // no action gives all-zero fields
    a_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_action == acr_pkg::ACT_NONE |->
        o_dest_mac == '0 && o_dest_ip == '0 && o_frame_protocol == '0)
        else $error("nonzero fields with no action");

    // ARP frames carry the ARP ethertype
    a_arp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_action == acr_pkg::ACT_REQUEST || o_action == acr_pkg::ACT_REPLY)
        |-> o_frame_protocol == acr_pkg::ARP_ETHERTYPE)
        else $error("ARP frame without ARP ethertype");
endmodule

bind arp_cache_resolver_core acr_checker u_acr_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_valid(o_valid), .i_ready(i_ready),
    .o_action(o_action), .o_dest_mac(o_dest_mac), .o_dest_ip(o_dest_ip),
    .o_frame_protocol(o_frame_protocol)
);

### sim/tb_arp_cache_resolver_core.sv
// Self-checking testbench for arp_cache_resolver_core: ARP header and lookup words
// against a local cache predictor. Depends on acr_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_arp_cache_resolver_core;
    localparam int N_ENT     = 8;
    localparam int WDOG_MAX  = 20000;
    localparam int DRAIN_CYC = 64;

    localparam logic [2:0] A_LOCAL_IP = {acr_pkg::REG_LOCAL_IP, 2'b00};
    localparam logic [2:0] A_LIFETIME = {acr_pkg::REG_LIFETIME, 2'b00};

    typedef struct packed {
        logic        cmd;
        logic [31:0] now;
        logic [15:0] hw_type;
        logic [15:0] proto_type;
        logic [7:0]  hw_len;
        logic [7:0]  proto_len;
        logic [15:0] opcode;
        logic [31:0] src_ip;
        logic [47:0] src_mac;
        logic [31:0] dst_ip;
        logic [15:0] upper_protocol;
    } t_arp_word;

    typedef struct packed {
        logic [2:0]  action;
        logic [47:0] mac;
        logic [31:0] ip;
        logic [15:0] proto;
    } t_verdict;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic        i_cmd = 1'b0;
    logic [31:0] i_now_seconds = '0;
    logic [15:0] i_hw_type = '0;
    logic [15:0] i_proto_type = '0;
    logic [7:0]  i_hw_len = '0;
    logic [7:0]  i_proto_len = '0;
    logic [15:0] i_opcode = '0;
    logic [31:0] i_src_ip = '0;
    logic [47:0] i_src_mac = '0;
    logic [31:0] i_dst_ip = '0;
    logic [15:0] i_upper_protocol = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [2:0]  o_action;
    logic [47:0] o_dest_mac;
    logic [31:0] o_dest_ip;
    logic [15:0] o_frame_protocol;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    arp_cache_resolver_core #(.TABLE_ENTRIES(N_ENT)) dut (.*);

    // Predictor state
    logic [31:0] cache_ip     [N_ENT];
    logic [47:0] cache_mac    [N_ENT];
    logic [31:0] cache_expiry [N_ENT];
    logic        cache_valid  [N_ENT];
    logic        park_valid;
    logic [31:0] park_ip;
    logic [15:0] park_proto;
    logic [31:0] cfg_local_ip;
    logic [15:0] cfg_lifetime;

    t_arp_word send_q[$];
    t_verdict  verdict_q[$];
    int        mismatches = 0;
    int        idle_pct = 27;
    int        quiet_cycles = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic int cache_find(logic [31:0] ip);
        for (int k = 0; k < N_ENT; k++)
            if (cache_valid[k] && cache_ip[k] == ip) return k;
        return -1;
    endfunction

    // Ages the table and learns the sender, as the block does per good header
    function automatic void cache_learn(logic [31:0] now, logic [31:0] ip,
                                        logic [47:0] mac);
        int slot;
        logic [32:0] sum;
        slot = -1;
        for (int k = 0; k < N_ENT; k++)
            if (cache_valid[k] && now > cache_expiry[k]) cache_valid[k] = 1'b0;
        for (int k = 0; k < N_ENT; k++)
            if (slot < 0 && !cache_valid[k]) slot = k;
        if (slot < 0) begin
            slot = 0;
            for (int k = 1; k < N_ENT; k++)
                if (cache_expiry[k] < cache_expiry[slot]) slot = k;
        end
        sum = {1'b0, now} + {17'b0, cfg_lifetime};
        cache_ip[slot]     = ip;
        cache_mac[slot]    = mac;
        cache_expiry[slot] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        cache_valid[slot]  = 1'b1;
    endfunction

    function automatic t_verdict resolve(t_arp_word w);
        t_verdict v;
        int hit;
        v = '0;
        if (!w.cmd) begin
            if (w.hw_type == acr_pkg::HW_ETHERNET && w.proto_type == acr_pkg::PROTO_IPV4
                && w.hw_len == 8'd6 && w.proto_len == 8'd4
                && (w.opcode == acr_pkg::OP_REQUEST || w.opcode == acr_pkg::OP_REPLY)) begin
                cache_learn(w.now, w.src_ip, w.src_mac);
                if (park_valid) begin
                    hit = cache_find(park_ip);
                    if (hit >= 0) begin
                        park_valid = 1'b0;
                        v.action = acr_pkg::ACT_RELEASE;
                        v.mac = cache_mac[hit];
                        v.proto = park_proto;
                    end
                end else if (w.opcode == acr_pkg::OP_REQUEST && w.dst_ip == cfg_local_ip) begin
                    v.action = acr_pkg::ACT_REPLY;
                    v.mac = w.src_mac;
                    v.ip = w.src_ip;
                    v.proto = acr_pkg::ARP_ETHERTYPE;
                end
            end
        end else begin
            hit = cache_find(w.dst_ip);
            if (hit >= 0) begin
                v.action = acr_pkg::ACT_DIRECT;
                v.mac = cache_mac[hit];
                v.proto = w.upper_protocol;
            end else begin
                v.action = acr_pkg::ACT_REQUEST;
                v.ip = w.dst_ip;
                v.proto = acr_pkg::ARP_ETHERTYPE;
                park_valid = 1'b1;
                park_ip = w.dst_ip;
                park_proto = w.upper_protocol;
            end
        end
        return v;
    endfunction

    // Driver: presents queued words, holds until accepted
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                verdict_q.push_back(resolve(send_q.pop_front()));
            end
            if (!i_valid || o_ready) begin
                if (send_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
                    i_valid          <= 1'b1;
                    i_cmd            <= send_q[0].cmd;
                    i_now_seconds    <= send_q[0].now;
                    i_hw_type        <= send_q[0].hw_type;
                    i_proto_type     <= send_q[0].proto_type;
                    i_hw_len         <= send_q[0].hw_len;
                    i_proto_len      <= send_q[0].proto_len;
                    i_opcode         <= send_q[0].opcode;
                    i_src_ip         <= send_q[0].src_ip;
                    i_src_mac        <= send_q[0].src_mac;
                    i_dst_ip         <= send_q[0].dst_ip;
                    i_upper_protocol <= send_q[0].upper_protocol;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compares each result word with the oldest prediction
    always @(posedge i_clk) begin
        t_verdict exp_v;
        if (i_rst_n) begin
            i_ready <= ($urandom_range(99) >= idle_pct);
            if (o_valid && i_ready) begin
                if (verdict_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result word: action %0d", o_action);
                end else begin
                    exp_v = verdict_q.pop_front();
                    if (o_action !== exp_v.action || o_dest_mac !== exp_v.mac
                        || o_dest_ip !== exp_v.ip || o_frame_protocol !== exp_v.proto) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: exp act %0d mac %h ip %h proto %h,",
                                      " got act %0d mac %h ip %h proto %h"},
                                     exp_v.action, exp_v.mac, exp_v.ip, exp_v.proto,
                                     o_action, o_dest_mac, o_dest_ip, o_frame_protocol);
                    end
                end
            end
        end
    end

    // Watchdog on handshake inactivity
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WDOG_MAX) begin
            $display("arp_cache_resolver_core verification failed");
            $finish;
        end
    end

    task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (addr == A_LOCAL_IP) cfg_local_ip = data;
        else cfg_lifetime = data[15:0];
    endtask

    task automatic wait_drained();
        while (send_q.size() != 0 || verdict_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    // Small pool of addresses so lookups hit and the table fills
    logic [31:0] clock_s = 32'd100;
    function automatic logic [31:0] pool_ip();
        if ($urandom_range(9) == 0) return $urandom();
        return 32'h0A00_0000 | $urandom_range(11);
    endfunction

    function automatic t_arp_word good_header(logic [15:0] op, logic [31:0] tgt);
        t_arp_word w;
        w.cmd = 1'b0; w.now = clock_s;
        w.hw_type = acr_pkg::HW_ETHERNET; w.proto_type = acr_pkg::PROTO_IPV4;
        w.hw_len = 8'd6; w.proto_len = 8'd4; w.opcode = op;
        w.src_ip = pool_ip();
        w.src_mac = 48'({$urandom(), $urandom()});
        w.dst_ip = tgt;
        w.upper_protocol = 16'($urandom());
        return w;
    endfunction

    task automatic queue_random(int count);
        t_arp_word w;
        int r;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(3) == 0)
                clock_s = (clock_s > 32'hFFFF_FF00) ? clock_s : clock_s + $urandom_range(40);
            r = $urandom_range(99);
            if (r < 45) begin
                w = good_header($urandom_range(1) ? acr_pkg::OP_REQUEST : acr_pkg::OP_REPLY,
                                $urandom_range(1) ? cfg_local_ip : pool_ip());
            end else if (r < 85) begin
                w = good_header(acr_pkg::OP_REQUEST, pool_ip());
                w.cmd = 1'b1;
            end else begin
                w = good_header(acr_pkg::OP_REQUEST, pool_ip());
                {w.hw_type, w.proto_type, w.hw_len, w.proto_len, w.opcode} =
                    {$urandom(), $urandom()};
                if ($urandom_range(1)) w.proto_type = acr_pkg::PROTO_IPV4;
                if ($urandom_range(1)) w.hw_len = 8'd6;
            end
            send_q.push_back(w);
        end
    endtask

    initial begin
        t_arp_word w;
        for (int k = 0; k < N_ENT; k++) cache_valid[k] = 1'b0;
        park_valid = 1'b0;
        cfg_local_ip = '0;
        cfg_lifetime = 16'd60;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed words
        reg_write(A_LOCAL_IP, 32'h0A00_0005);
        w = good_header(acr_pkg::OP_REQUEST, 32'h0A00_0005); send_q.push_back(w); // reply
        w.cmd = 1'b1; w.dst_ip = w.src_ip; send_q.push_back(w);                   // direct
        w.dst_ip = 32'hC0A8_0001; send_q.push_back(w);                            // park
        w = good_header(acr_pkg::OP_REQUEST, 32'h0A00_0005); send_q.push_back(w); // unresolved
        w = good_header(acr_pkg::OP_REPLY, 32'h0); w.src_ip = 32'hC0A8_0001;
        send_q.push_back(w);                                                      // release
        w = good_header(acr_pkg::OP_REQUEST, 32'h0A00_0005);
        w.hw_type = 16'hFFFF; send_q.push_back(w);
        w.hw_type = acr_pkg::HW_ETHERNET; w.proto_type = 16'h0; send_q.push_back(w);
        w.proto_type = acr_pkg::PROTO_IPV4; w.hw_len = 8'hFF; send_q.push_back(w);
        w.hw_len = 8'd6; w.proto_len = 8'h0; send_q.push_back(w);
        w.proto_len = 8'd4; w.opcode = 16'hFFFF; send_q.push_back(w);
        w.opcode = 16'h0; send_q.push_back(w);
        w.opcode = 16'd3; send_q.push_back(w);
        for (int k = 0; k < 10; k++) begin                                // fill, then replace
            w = good_header(acr_pkg::OP_REPLY, 32'h0);
            w.src_ip = 32'h1400_0000 + k; w.now = clock_s + k; send_q.push_back(w);
        end
        clock_s = clock_s + 10;
        wait_drained();

        // Extreme settings: maximum lifetime with saturating expiry, all-ones address
        reg_write(A_LIFETIME, 32'h0000_FFFF);
        reg_write(A_LOCAL_IP, 32'hFFFF_FFFF);
        clock_s = 32'hFFFF_FFF0;
        w = good_header(acr_pkg::OP_REQUEST, 32'hFFFF_FFFF);
        w.src_ip = 32'hFFFF_FFFF; w.src_mac = 48'hFFFF_FFFF_FFFF; send_q.push_back(w);
        w.cmd = 1'b1; w.upper_protocol = 16'hFFFF; w.dst_ip = 32'hFFFF_FFFF;
        send_q.push_back(w);
        w = good_header(acr_pkg::OP_REQUEST, 32'h0); w.src_ip = 32'h0;
        w.src_mac = 48'h0; w.upper_protocol = 16'h0; send_q.push_back(w);
        queue_random(80);
        wait_drained();

        // Minimum lifetime, fast ageing; time restarts from a low value after idle
        reg_write(A_LIFETIME, 32'd1);
        reg_write(A_LOCAL_IP, 32'h0A00_0003);
        queue_random(20);
        wait_drained();
        reg_write(A_LIFETIME, 32'd1);
        clock_s = 32'd0;
        w = good_header(acr_pkg::OP_REPLY, 32'h0); w.now = 32'h0; w.src_ip = 32'hDEAD_0000;
        send_q.push_back(w);
        queue_random(400);
        wait_drained();

        // Mid lifetime, no idling stretch
        reg_write(A_LIFETIME, 32'd30);
        reg_write(A_LOCAL_IP, 32'h0A00_0007);
        idle_pct = 0;
        queue_random(300);
        wait_drained();
        idle_pct = 27;
        reg_write(A_LIFETIME, 32'd200);
        queue_random(530);
        wait_drained();

        if (mismatches == 0)
            $display("arp_cache_resolver_core verification clean");
        else
            $display("arp_cache_resolver_core verification failed");
        $finish;
    end
endmodule
